// ----- sv/ntps_pkg.sv -----
// Package for the nearest three planes selector.
// Holds widths, register map, saturation limit and the stage-to-stage structs.
// No dependencies.
package ntps_pkg;

  localparam int unsigned MAX_PLANES = 1024;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned DIST_W     = 31;
  localparam int unsigned SLOTS      = 3;
  localparam int unsigned APB_AW     = 3;
  localparam int unsigned APB_DW     = 32;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  localparam logic [APB_AW-1:0] ADDR_MAX_DISTANCE = 3'd0;

  typedef struct packed {
    logic               considered;
    logic [DIST_W-1:0]  distance;
    logic [IDX_W-1:0]   plane;
    logic               first;
    logic               last;
  } ntps_dist_t;

  typedef struct packed {
    logic signed [47:0] prod_x;
    logic signed [47:0] prod_y;
    logic signed [47:0] prod_z;
    logic signed [31:0] offset;
    logic               considered;
    logic [IDX_W-1:0]   plane;
    logic               first;
    logic               last;
  } ntps_prod_t;

endpackage

// ----- sv/ntps_in_if.sv -----
// Input channel of the nearest three planes selector: one plane per item.
// Depends on ntps_pkg.
interface ntps_in_if
  import ntps_pkg::*;
();
  logic                valid;
  logic                ready;
  logic signed [31:0]  point_x;
  logic signed [31:0]  point_y;
  logic signed [31:0]  point_z;
  logic signed [15:0]  normal_x;
  logic signed [15:0]  normal_y;
  logic signed [15:0]  normal_z;
  logic signed [31:0]  plane_offset;
  logic [IDX_W-1:0]    plane_number;
  logic                first_plane;
  logic                last_plane;

  modport source (
    output valid, point_x, point_y, point_z, normal_x, normal_y, normal_z,
           plane_offset, plane_number, first_plane, last_plane,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, point_z, normal_x, normal_y, normal_z,
           plane_offset, plane_number, first_plane, last_plane,
    output ready
  );
endinterface

// ----- sv/ntps_out_if.sv -----
// Result channel of the nearest three planes selector: one item per voxel.
// Depends on ntps_pkg.
interface ntps_out_if
  import ntps_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [IDX_W-1:0]    nearest_index_a;
  logic [IDX_W-1:0]    nearest_index_b;
  logic [IDX_W-1:0]    nearest_index_c;
  logic [DIST_W-1:0]   nearest_dist_a;
  logic [DIST_W-1:0]   nearest_dist_b;
  logic [DIST_W-1:0]   nearest_dist_c;
  logic [1:0]          filled_slots;

  modport source (
    output valid, nearest_index_a, nearest_index_b, nearest_index_c,
           nearest_dist_a, nearest_dist_b, nearest_dist_c, filled_slots,
    input  ready
  );
  modport sink (
    input  valid, nearest_index_a, nearest_index_b, nearest_index_c,
           nearest_dist_a, nearest_dist_b, nearest_dist_c, filled_slots,
    output ready
  );
endinterface

// ----- sv/nearest_three_planes_selector_unit.sv -----
// Nearest three planes selector, top level.
// A result passes the product register, the distance register and the result register.
// Throughput: one plane per cycle, unless a last plane meets a result still held on out_ch;
// set by the product stage, the sum and rounding stage and the top-3 update, each one register apart.
// Reset: asynchronous active low; clears pipeline valids, the slot fill
// and the result valid, and sets max_distance to 0x7FFFFFFF.
module nearest_three_planes_selector_unit
  import ntps_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  ntps_in_if.sink            in_ch_i,
  ntps_out_if.source         out_ch_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  logic [DIST_W-1:0] max_dist;
  logic              adv;
  logic              dist_valid;
  ntps_dist_t        dist_item;

  ntps_apb_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .max_dist_o (max_dist)
  );

  ntps_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (in_ch_i),
    .adv_i   (adv),
    .valid_o (dist_valid),
    .item_o  (dist_item)
  );

  ntps_select u_select (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (dist_valid),
    .item_i     (dist_item),
    .max_dist_i (max_dist),
    .adv_o      (adv),
    .out_ch     (out_ch_o)
  );

endmodule

// ----- sv/ntps_apb_regs.sv -----
// APB configuration register block: holds max_distance.
// Depends on ntps_pkg.
module ntps_apb_regs
  import ntps_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready,
  output logic [DIST_W-1:0]  max_dist_o
);

  logic [DIST_W-1:0] max_dist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dist_q <= DIST_MAX;
    end else if (psel && penable && pwrite && (paddr == ADDR_MAX_DISTANCE)) begin
      max_dist_q <= pwdata[DIST_W-1:0];
    end
  end

  always_comb begin
    case (paddr)
      ADDR_MAX_DISTANCE: prdata = {{(APB_DW-DIST_W){1'b0}}, max_dist_q};
      default:           prdata = '0;
    endcase
  end

  assign pready     = 1'b1;
  assign max_dist_o = max_dist_q;

endmodule

// ----- sv/ntps_dist.sv -----
// Two-stage point-to-plane distance pipeline: products, then sum, abs,
// rounding and saturation to unsigned Q15.16. Depends on ntps_pkg and ntps_in_if.
module ntps_dist
  import ntps_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  ntps_in_if.sink     in_ch,
  input  logic        adv_i,
  output logic        valid_o,
  output ntps_dist_t  item_o
);

  logic       s1_valid_q;
  ntps_prod_t s1_q;
  ntps_prod_t s1_d;
  logic       s2_valid_q;
  ntps_dist_t s2_q;
  ntps_dist_t s2_d;

  logic signed [51:0] dot;
  logic signed [51:0] off_sc;
  logic signed [51:0] diff;
  logic [51:0]        mag;
  logic [51:0]        rnd;
  logic [37:0]        quo;

  assign in_ch.ready = adv_i;

  always_comb begin
    s1_d.prod_x     = in_ch.point_x * in_ch.normal_x;
    s1_d.prod_y     = in_ch.point_y * in_ch.normal_y;
    s1_d.prod_z     = in_ch.point_z * in_ch.normal_z;
    s1_d.offset     = in_ch.plane_offset;
    s1_d.considered = (32'(in_ch.plane_number) < MAX_PLANES);
    s1_d.plane      = in_ch.plane_number;
    s1_d.first      = in_ch.first_plane;
    s1_d.last       = in_ch.last_plane;
  end

  always_comb begin
    dot    = {{4{s1_q.prod_x[47]}}, s1_q.prod_x}
           + {{4{s1_q.prod_y[47]}}, s1_q.prod_y}
           + {{4{s1_q.prod_z[47]}}, s1_q.prod_z};
    off_sc = {{6{s1_q.offset[31]}}, s1_q.offset, 14'd0};
    diff   = dot - off_sc;
    mag    = diff[51] ? 52'(-diff) : 52'(diff);
    rnd    = mag + 52'd8192;
    quo    = rnd[51:14];
    s2_d.considered = s1_q.considered;
    s2_d.distance   = (|quo[37:DIST_W]) ? DIST_MAX : quo[DIST_W-1:0];
    s2_d.plane      = s1_q.plane;
    s2_d.first      = s1_q.first;
    s2_d.last       = s1_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (adv_i) begin
      s1_valid_q <= in_ch.valid;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
    end
  end

  assign valid_o = s2_valid_q;
  assign item_o  = s2_q;

endmodule

// ----- sv/ntps_select.sv -----
// Sorted top-3 nearest plane store and result register.
// Depends on ntps_pkg and ntps_out_if.
module ntps_select
  import ntps_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  ntps_dist_t         item_i,
  input  logic [DIST_W-1:0]  max_dist_i,
  output logic               adv_o,
  ntps_out_if.source         out_ch
);

  logic [DIST_W-1:0] dist_q [SLOTS];
  logic [IDX_W-1:0]  idx_q  [SLOTS];
  logic [1:0]        fill_q;
  logic [DIST_W-1:0] dist_n [SLOTS];
  logic [IDX_W-1:0]  idx_n  [SLOTS];
  logic [1:0]        fill_b;
  logic [1:0]        fill_n;
  logic [1:0]        pos;
  logic              ins;
  logic              take;

  logic              out_valid_q;
  logic [IDX_W-1:0]  out_idx_q  [SLOTS];
  logic [DIST_W-1:0] out_dist_q [SLOTS];
  logic [1:0]        out_fill_q;

  assign adv_o = !(valid_i && item_i.last && out_valid_q && !out_ch.ready);
  assign take  = valid_i && adv_o;

  always_comb begin
    fill_b = item_i.first ? 2'd0 : fill_q;
    pos    = 2'(SLOTS);
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (item_i.distance <= ((2'(k) < fill_b) ? dist_q[k] : max_dist_i)) begin
        pos = 2'(k);
      end
    end
    ins = item_i.considered && (pos != 2'(SLOTS));
    for (int k = 0; k < SLOTS; k++) begin
      dist_n[k] = dist_q[k];
      idx_n[k]  = idx_q[k];
      if (ins && (2'(k) == pos)) begin
        dist_n[k] = item_i.distance;
        idx_n[k]  = item_i.plane;
      end else if (ins && (2'(k) > pos) && (k > 0)) begin
        dist_n[k] = dist_q[(k > 0) ? k-1 : 0];
        idx_n[k]  = idx_q[(k > 0) ? k-1 : 0];
      end
    end
    fill_n = (ins && (fill_b != 2'(SLOTS))) ? fill_b + 2'd1 : fill_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        fill_q <= item_i.last ? 2'd0 : fill_n;
      end
      if (take && item_i.last) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      dist_q <= dist_n;
      idx_q  <= idx_n;
    end
    if (take && item_i.last) begin
      for (int k = 0; k < SLOTS; k++) begin
        out_idx_q[k]  <= (2'(k) < fill_n) ? idx_n[k]  : '0;
        out_dist_q[k] <= (2'(k) < fill_n) ? dist_n[k] : max_dist_i;
      end
      out_fill_q <= fill_n;
    end
  end

  assign out_ch.valid           = out_valid_q;
  assign out_ch.nearest_index_a = out_idx_q[0];
  assign out_ch.nearest_index_b = out_idx_q[1];
  assign out_ch.nearest_index_c = out_idx_q[2];
  assign out_ch.nearest_dist_a  = out_dist_q[0];
  assign out_ch.nearest_dist_b  = out_dist_q[1];
  assign out_ch.nearest_dist_c  = out_dist_q[2];
  assign out_ch.filled_slots    = out_fill_q;

endmodule

// ----- tb/tb_nearest_three_planes_selector_unit.sv -----
// Testbench for nearest_three_planes_selector_unit: directed and random planes per voxel,
// APB writes of max_distance between phases, scoreboard predicting the sorted top-3.
// Depends on ntps_pkg, ntps_in_if, ntps_out_if and the top level RTL.
module tb_nearest_three_planes_selector_unit;
  import ntps_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned PHASE_ITEMS  = 75;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam longint      S32_MIN      = -64'sd2147483648;
  localparam longint      S32_MAX      = 64'sd2147483647;

  typedef struct {
    logic signed [31:0] px, py, pz;
    logic signed [15:0] nx, ny, nz;
    logic signed [31:0] offset;
    logic [IDX_W-1:0]   num;
    logic               first, last;
  } plane_item_t;

  typedef struct packed {
    logic [SLOTS-1:0][IDX_W-1:0]  slot_plane;
    logic [SLOTS-1:0][DIST_W-1:0] slot_dist;
    logic [1:0]                   filled;
  } voxel_result_t;

  class nearest_plane_board;
    logic [DIST_W-1:0] limit_dist;
    logic [DIST_W-1:0] best_dist [SLOTS];
    logic [IDX_W-1:0]  best_plane [SLOTS];
    int unsigned       fill;
    voxel_result_t     expected_q [$];
    int unsigned       errors;

    function new();
      limit_dist = DIST_MAX;
      errors = 0;
      clear_selection();
    endfunction

    function void clear_selection();
      for (int k = 0; k < SLOTS; k++) begin
        best_dist[k] = limit_dist;
        best_plane[k] = '0;
      end
      fill = 0;
    endfunction

    function void set_limit(logic [DIST_W-1:0] v);
      limit_dist = v;
    endfunction

    function logic [DIST_W-1:0] plane_distance(plane_item_t p);
      longint     dot;
      longint     diff;
      logic [63:0] mag;
      logic [63:0] q;
      dot = longint'(p.nx) * longint'(p.px) + longint'(p.ny) * longint'(p.py)
          + longint'(p.nz) * longint'(p.pz);
      diff = dot - longint'(p.offset) * 16384;
      mag = (diff < 0) ? -diff : diff;
      q = (mag + 64'd8192) >> 14;
      if (q > DIST_MAX) q = DIST_MAX;
      return q[DIST_W-1:0];
    endfunction

    function void note_plane(plane_item_t p);
      logic [DIST_W-1:0] d;
      logic [DIST_W-1:0] lim;
      int                pos;
      voxel_result_t     r;
      if (p.first) clear_selection();
      if (p.num < MAX_PLANES) begin
        d = plane_distance(p);
        pos = SLOTS;
        for (int k = 0; k < SLOTS; k++) begin
          lim = (k < fill) ? best_dist[k] : limit_dist;
          if (pos == SLOTS && d <= lim) pos = k;
        end
        if (pos < SLOTS) begin
          for (int k = SLOTS - 1; k > pos; k--) begin
            best_dist[k] = best_dist[k-1];
            best_plane[k] = best_plane[k-1];
          end
          best_dist[pos] = d;
          best_plane[pos] = p.num;
          if (fill < SLOTS) fill++;
        end
      end
      if (p.last) begin
        for (int k = 0; k < SLOTS; k++) begin
          r.slot_plane[k] = (k < fill) ? best_plane[k] : '0;
          r.slot_dist[k] = (k < fill) ? best_dist[k] : limit_dist;
        end
        r.filled = 2'(fill);
        expected_q = {expected_q, r};
        clear_selection();
      end
    endfunction

    task report(string msg);
      if (errors < 50) $display("%0t mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(voxel_result_t got);
      voxel_result_t want;
      if (expected_q.size() == 0) begin
        report("result item with no voxel pending");
        return;
      end
      want = expected_q.pop_front();
      for (int k = 0; k < SLOTS; k++) begin
        if (got.slot_plane[k] !== want.slot_plane[k])
          report($sformatf("slot %0d index got %0d want %0d", k,
                           got.slot_plane[k], want.slot_plane[k]));
        if (got.slot_dist[k] !== want.slot_dist[k])
          report($sformatf("slot %0d distance got %h want %h", k,
                           got.slot_dist[k], want.slot_dist[k]));
      end
      if (got.filled !== want.filled)
        report($sformatf("filled_slots got %0d want %0d", got.filled, want.filled));
    endtask
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  ntps_in_if  in_ch ();
  ntps_out_if out_ch ();

  nearest_plane_board board = new();

  int unsigned       gap_pct;
  int unsigned       stall_pct;
  int unsigned       hold_reqs;
  int unsigned       items_sent;
  int unsigned       cycle_count;
  logic [DIST_W-1:0] cur_limit;
  longint            last_dist;
  plane_item_t       prev_plane;
  bit                have_prev;

  nearest_three_planes_selector_unit u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch_i  (in_ch),
    .out_ch_o (out_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_nearest_three_planes_selector_unit: errors");
    $finish;
  end

  always @(posedge clk_i) begin
    plane_item_t seen;
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      seen.px = in_ch.point_x;
      seen.py = in_ch.point_y;
      seen.pz = in_ch.point_z;
      seen.nx = in_ch.normal_x;
      seen.ny = in_ch.normal_y;
      seen.nz = in_ch.normal_z;
      seen.offset = in_ch.plane_offset;
      seen.num = in_ch.plane_number;
      seen.first = in_ch.first_plane;
      seen.last = in_ch.last_plane;
      board.note_plane(seen);
    end
  end

  always @(posedge clk_i) begin
    voxel_result_t got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.slot_plane[0] = out_ch.nearest_index_a;
      got.slot_plane[1] = out_ch.nearest_index_b;
      got.slot_plane[2] = out_ch.nearest_index_c;
      got.slot_dist[0] = out_ch.nearest_dist_a;
      got.slot_dist[1] = out_ch.nearest_dist_b;
      got.slot_dist[2] = out_ch.nearest_dist_c;
      got.filled = out_ch.filled_slots;
      board.check_result(got);
    end
  end

  initial begin
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_plane(input plane_item_t p);
    while ($urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.point_x <= p.px;
    in_ch.point_y <= p.py;
    in_ch.point_z <= p.pz;
    in_ch.normal_x <= p.nx;
    in_ch.normal_y <= p.ny;
    in_ch.normal_z <= p.nz;
    in_ch.plane_offset <= p.offset;
    in_ch.plane_number <= p.num;
    in_ch.first_plane <= p.first;
    in_ch.last_plane <= p.last;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [DIST_W-1:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_MAX_DISTANCE;
    pwdata <= APB_DW'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    board.set_limit(v);
    cur_limit = v;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== APB_DW'(v))
      board.report($sformatf("max_distance read %h want %h", prdata, v));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic plane_item_t make_plane(
    input logic signed [31:0] px, py, pz,
    input logic signed [15:0] nx, ny, nz,
    input logic signed [31:0] off,
    input logic [IDX_W-1:0]   num,
    input logic               first, last
  );
    plane_item_t p;
    p.px = px;
    p.py = py;
    p.pz = pz;
    p.nx = nx;
    p.ny = ny;
    p.nz = nz;
    p.offset = off;
    p.num = num;
    p.first = first;
    p.last = last;
    return p;
  endfunction

  // x normal at x = 100: distance is exactly |100 - offset|
  function automatic plane_item_t axis_item(
    input longint d, input logic [IDX_W-1:0] num, input logic first, last
  );
    return make_plane(100, -7, 3, 16'sd16384, 0, 0, 32'(100 - d), num, first, last);
  endfunction

  function automatic longint pick_distance();
    longint d;
    case ($urandom_range(7))
      0: d = 0;
      1: d = longint'(cur_limit);
      2: d = (cur_limit == DIST_MAX) ? longint'(cur_limit) : longint'(cur_limit) + 1;
      3: d = (cur_limit == 0) ? 0 : longint'(cur_limit) - 1;
      4: d = last_dist;
      5: d = longint'($urandom_range(cur_limit));
      default: d = longint'($urandom_range(4096));
    endcase
    last_dist = d;
    return d;
  endfunction

  function automatic plane_item_t random_plane(
    input plane_item_t pt, input logic first, input logic last
  );
    plane_item_t       p;
    longint            c;
    longint            off;
    longint            dot;
    logic signed [15:0] sgn;
    int unsigned       mode;
    p = pt;
    mode = $urandom_range(99);
    if (mode < 15 && have_prev) begin
      p.nx = prev_plane.nx;
      p.ny = prev_plane.ny;
      p.nz = prev_plane.nz;
      p.offset = prev_plane.offset;
    end else if (mode < 55) begin
      sgn = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
      p.nx = 0;
      p.ny = 0;
      p.nz = 0;
      case ($urandom_range(2))
        0: begin p.nx = sgn; c = longint'(p.px); end
        1: begin p.ny = sgn; c = longint'(p.py); end
        default: begin p.nz = sgn; c = longint'(p.pz); end
      endcase
      if (sgn < 0) c = -c;
      off = c - pick_distance();
      if (off < S32_MIN) off = c + last_dist;
      if (off > S32_MAX) off = S32_MAX;
      p.offset = off[31:0];
    end else begin
      p.nx = 16'($urandom_range(32768)) - 16'd16384;
      p.ny = 16'($urandom_range(32768)) - 16'd16384;
      p.nz = 16'($urandom_range(32768)) - 16'd16384;
      dot = longint'(p.nx) * longint'(p.px) + longint'(p.ny) * longint'(p.py)
          + longint'(p.nz) * longint'(p.pz);
      off = (dot >>> 14) + longint'($urandom_range(262144)) - 131072;
      if (mode >= 90 || off < S32_MIN || off > S32_MAX) p.offset = $urandom;
      else p.offset = off[31:0];
    end
    case ($urandom_range(9))
      0: p.num = '0;
      1: p.num = '1;
      default: p.num = IDX_W'($urandom_range(1023));
    endcase
    p.first = first;
    p.last = last;
    prev_plane = p;
    have_prev = 1'b1;
    return p;
  endfunction

  task automatic send_voxel(input int unsigned n, input logic with_first, with_last);
    plane_item_t pt;
    if ($urandom_range(3) == 0) begin
      pt.px = $urandom;
      pt.py = $urandom;
      pt.pz = $urandom;
    end else begin
      pt.px = 32'($urandom_range(2097152)) - 32'd1048576;
      pt.py = 32'($urandom_range(2097152)) - 32'd1048576;
      pt.pz = 32'($urandom_range(2097152)) - 32'd1048576;
    end
    have_prev = 1'b0;
    for (int unsigned i = 0; i < n; i++)
      send_plane(random_plane(pt, with_first && i == 0, with_last && i == n - 1));
  endtask

  task automatic run_phase(
    input logic [DIST_W-1:0] limit, input int unsigned gap, stall, max_len,
    input bit hold, pause
  );
    int unsigned start;
    int unsigned n;
    bit          paused;
    paused = 1'b0;
    wait_for_results();
    write_limit(limit);
    gap_pct = gap;
    stall_pct = stall;
    if (hold) hold_reqs++;
    start = items_sent;
    while (items_sent - start < PHASE_ITEMS) begin
      if (pause && !paused && items_sent - start >= PHASE_ITEMS / 2) begin
        wait_for_results();
        paused = 1'b1;
      end
      n = ($urandom_range(15) == 0) ? $urandom_range(12, 7) : $urandom_range(max_len, 1);
      send_voxel(n, $urandom_range(9) != 0, $urandom_range(11) != 0);
    end
  endtask

  initial begin
    gap_pct = 0;
    stall_pct = 0;
    hold_reqs = 0;
    items_sent = 0;
    cur_limit = DIST_MAX;
    last_dist = 0;
    have_prev = 1'b0;
    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.point_x <= '0;
    in_ch.point_y <= '0;
    in_ch.point_z <= '0;
    in_ch.normal_x <= '0;
    in_ch.normal_y <= '0;
    in_ch.normal_z <= '0;
    in_ch.plane_offset <= '0;
    in_ch.plane_number <= '0;
    in_ch.first_plane <= 1'b0;
    in_ch.last_plane <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_plane(make_plane(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'sd16384,
                          16'sd16384, 16'sd16384, 32'h8000_0000, 10'd1023, 1'b1, 1'b1));
    send_plane(make_plane(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, -16'sd16384,
                          -16'sd16384, -16'sd16384, 32'h7FFF_FFFF, 10'd0, 1'b1, 1'b1));
    send_plane(make_plane(32'h8000_0000, 32'h7FFF_FFFF, 0, -16'sd16384, 16'sd16384, 0,
                          0, 10'd512, 1'b1, 1'b1));
    send_plane(make_plane(1, 0, 0, 8192, 0, 0, 0, 10'd5, 1'b1, 1'b0));
    send_plane(make_plane(1, 0, 0, 8191, 0, 0, 0, 10'd6, 1'b0, 1'b0));
    send_plane(make_plane(1, 0, 0, -8192, 0, 0, 0, 10'd7, 1'b0, 1'b0));
    send_plane(make_plane(0, 0, 0, 0, 0, 0, 0, 10'd8, 1'b0, 1'b1));
    send_plane(axis_item(5, 10'd10, 1'b1, 1'b0));
    send_plane(axis_item(3, 10'd11, 1'b0, 1'b0));
    send_plane(axis_item(3, 10'd12, 1'b0, 1'b0));
    send_plane(axis_item(7, 10'd13, 1'b0, 1'b0));
    send_plane(axis_item(5, 10'd14, 1'b0, 1'b0));
    send_plane(axis_item(0, 10'd15, 1'b0, 1'b1));
    send_plane(axis_item(20, 10'd1, 1'b1, 1'b1));
    send_plane(axis_item(9, 10'd2, 1'b0, 1'b0));
    send_plane(axis_item(4, 10'd3, 1'b1, 1'b0));
    send_plane(axis_item(4, 10'd4, 1'b0, 1'b1));
    send_plane(axis_item(32'h0002_0000, 10'd30, 1'b1, 1'b0));
    send_plane(axis_item(32'h0005_0000, 10'd31, 1'b0, 1'b0));
    // change the limit with a voxel still open
    wait_for_results();
    write_limit(31'h0003_0000);
    send_plane(axis_item(32'h0003_0000, 10'd32, 1'b0, 1'b0));
    send_plane(axis_item(32'h0003_0001, 10'd33, 1'b0, 1'b1));

    run_phase(DIST_MAX, 0, 0, 6, 1'b0, 1'b0);
    run_phase(31'h0003_0000, 48, 0, 6, 1'b0, 1'b1);
    run_phase('0, 0, 48, 6, 1'b0, 1'b0);
    run_phase(31'($urandom), 15, 15, 6, 1'b0, 1'b0);
    run_phase(31'h0000_1000, 0, 0, 2, 1'b1, 1'b0);
    run_phase(31'($urandom_range(32'h0010_0000, 1)), 48, 0, 8, 1'b0, 1'b0);
    run_phase(DIST_MAX - 31'd1, 0, 48, 6, 1'b0, 1'b0);
    run_phase(31'h0000_0800, 15, 15, 12, 1'b0, 1'b0);

    wait_for_results();
    if (board.expected_q.size() != 0) board.report("voxel results never arrived");
    if (board.errors == 0) begin
      $display("tb_nearest_three_planes_selector_unit: clean");
    end else begin
      $display("tb_nearest_three_planes_selector_unit: errors");
    end
    $finish;
  end

endmodule
